### hw/rtl/kens_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kens_pkg: shared types and constants for the Kepler Newton solver
// Payload structs, orbit and status codes, CORDIC angle tables.
// ----------------------------------------------------------------------------
package kens_pkg;

  localparam int ITER_BITS = 10;
  localparam int CORDIC_STEPS = 30;
  localparam int ITER_DEFAULT = 1000;

  typedef struct packed {
    logic [31:0]        eccentricity;
    logic signed [31:0] mean_anomaly;
  } kens_in_t;

  typedef struct packed {
    logic signed [31:0] anomaly;
    logic [1:0]         orbit_kind;
    logic [1:0]         status;
    logic [9:0]         iterations_used;
  } kens_out_t;

  typedef enum logic [1:0] {
    KIND_ELLIPTIC  = 2'd0,
    KIND_PARABOLIC = 2'd1,
    KIND_HYPERBOLIC = 2'd2
  } kens_kind_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_FLAT      = 2'd2,
    ST_SATURATED = 2'd3
  } kens_status_t;

  typedef enum logic [1:0] {
    REG_MAX_ITER  = 2'd0,
    REG_TOLERANCE = 2'd1,
    REG_DERIV_FLOOR = 2'd2
  } kens_reg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [31:0]        ecc;
    logic signed [31:0] m;
    logic signed [31:0] start;
    logic [1:0]         kind;
    logic               ov;
  } kens_job_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RED, S_MOD, S_FOLD, S_CORD, S_POST, S_MULS, S_MULC,
    S_FUNC, S_DIV, S_UPD, S_DONE
  } kens_state_t;

  localparam logic signed [63:0] PI_Q26 = 64'sd210828714;
  localparam logic signed [63:0] PI_Q30 = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [63:0] TWO_PI_Q30 = 64'sd6746518852;
  localparam logic signed [63:0] LN2_Q30 = 64'sd744261118;
  localparam logic signed [63:0] CIRC_GAIN = 64'sd652032874;
  localparam logic signed [63:0] HYP_GAIN_INV = 64'sd1296540104;
  localparam logic signed [63:0] MAG_CAP = 64'sd281474976710656;
  localparam logic signed [63:0] ONE_Q26 = 64'sd67108864;
  localparam logic signed [63:0] WMAX = 64'sd2147483647;
  localparam logic signed [63:0] WMIN = -64'sd2147483648;

  function automatic logic signed [63:0] circ_angle(input logic [5:0] i);
    logic signed [63:0] r;
    case (i)
      6'd0: r = 64'sd843314856;
      6'd1: r = 64'sd497837829;
      6'd2: r = 64'sd263043837;
      6'd3: r = 64'sd133525158;
      6'd4: r = 64'sd67021686;
      6'd5: r = 64'sd33543515;
      6'd6: r = 64'sd16775850;
      6'd7: r = 64'sd8388437;
      6'd8: r = 64'sd4194282;
      6'd9: r = 64'sd2097149;
      default: r = (i <= 6'd30) ? ((64'sd1 <<< (6'd30 - i)) - 64'sd1) : 64'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] hyp_angle(input logic [5:0] i);
    logic signed [63:0] r;
    case (i)
      6'd0: r = 64'sd0;
      6'd1: r = 64'sd589812981;
      6'd2: r = 64'sd274247418;
      6'd3: r = 64'sd134923406;
      6'd4: r = 64'sd67196450;
      6'd5: r = 64'sd33565361;
      6'd6: r = 64'sd16778581;
      6'd7: r = 64'sd8388778;
      6'd8: r = 64'sd4194325;
      6'd9: r = 64'sd2097154;
      default: r = (i <= 6'd30) ? (64'sd1 <<< (6'd30 - i)) : 64'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] sat_w(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > WMAX) r = WMAX;
    else if (v < WMIN) r = WMIN;
    else r = v;
    return r;
  endfunction

  function automatic logic sat_f(input logic signed [63:0] v);
    return (v > WMAX) || (v < WMIN);
  endfunction

endpackage

### hw/rtl/kens_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kens_front: input register and orbit classifier
// Accepts a transaction, sorts it by eccentricity and forms the Newton start.
// ----------------------------------------------------------------------------
module kens_front
  import kens_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  kens_in_t  in_data,
  output logic      job_valid,
  input  logic      job_stall,
  output kens_job_t job
);

  logic      hold_r;
  kens_in_t  data_r;
  logic [63:0] m64;
  logic [63:0] s64;

  assign in_stall = hold_r && job_stall;
  assign job_valid = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (!in_stall) begin
      hold_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data;
    end
  end

  always_comb begin
    m64 = 64'(signed'(data_r.mean_anomaly));
    job.ecc = data_r.eccentricity;
    job.m = data_r.mean_anomaly;
    if (data_r.eccentricity == 32'd268435456) begin
      job.kind = KIND_PARABOLIC;
      s64 = m64;
    end else if (data_r.eccentricity > 32'd268435456) begin
      job.kind = KIND_HYPERBOLIC;
      s64 = m64;
    end else if ($signed(m64) < PI_Q26) begin
      job.kind = KIND_ELLIPTIC;
      s64 = m64 + 64'(data_r.eccentricity >> 3);
    end else begin
      job.kind = KIND_ELLIPTIC;
      s64 = m64 - 64'(data_r.eccentricity >> 3);
    end
    job.start = 32'(sat_w(s64));
    job.ov = sat_f(s64);
  end

endmodule

### hw/rtl/kens_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kens_queue: two-entry job queue
// Decouples the classifier from the Newton engine.
// ----------------------------------------------------------------------------
module kens_queue
  import kens_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_stall,
  input  kens_job_t wr_data,
  output logic      rd_valid,
  input  logic      rd_stall,
  output kens_job_t rd_data
);

  kens_job_t   mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        wr_en, rd_en;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign wr_en = wr_valid && !wr_stall;
  assign rd_en = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

### hw/rtl/kens_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kens_back: Newton-Raphson engine
// Sequencer around a shared CORDIC datapath, an e-multiplier and a
// restoring divider; one result register toward the output.
// ----------------------------------------------------------------------------
module kens_back
  import kens_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_stall,
  input  kens_job_t job,
  input  logic [9:0]  max_iter,
  input  logic [30:0] tol,
  input  logic [15:0] dfloor,
  output logic      out_valid,
  input  logic      out_stall,
  output kens_out_t out_data
);

  kens_state_t state_r, state_nxt;
  kens_job_t   job_r;
  logic signed [63:0] a_r, x_r, y_r, z_r, s_r, c_r, num_r, den_r;
  logic [5:0]  k_r, i_r, rep_r, n_r;
  logic [2:0]  rcnt_r;
  logic        flip_r, neg_r, ov_r, qneg_r;
  logic [9:0]  steps_r;
  logic [1:0]  status_r;
  logic [63:0] un_r, ud_r, rem_r, q_r;
  logic [6:0]  dcnt_r;
  logic        ovalid_r;
  kens_out_t   out_r;
  logic        hyp;
  logic        cap_r;
  logic        stop_r;

  assign hyp = (job_r.kind == KIND_HYPERBOLIC);
  assign out_valid = ovalid_r;
  assign out_data = out_r;
  assign job_stall = (state_r != S_IDLE);

  // multiply by e, truncating toward zero
  function automatic logic signed [63:0] mul_ecc(input logic signed [63:0] a,
                                                 input logic [31:0] e);
    logic [63:0] mm, hi, lo, res;
    mm = a[63] ? 64'(-a) : 64'(a);
    if (mm > 64'(MAG_CAP)) mm = 64'(MAG_CAP);
    hi = (mm >> 24) * 64'(e);
    lo = (mm & 64'hFFFFFF) * 64'(e);
    res = (hi >> 4) + ((((hi & 64'd15) << 24) + lo) >> 28);
    return a[63] ? -$signed(res) : $signed(res);
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (job_valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = (job_r.kind == KIND_PARABOLIC || stop_r ||
                            steps_r >= max_iter) ? S_DONE : S_RED;
      S_RED:   state_nxt = S_MOD;
      S_MOD:   if (rcnt_r == 3'd0) state_nxt = S_FOLD;
      S_FOLD:  state_nxt = S_CORD;
      S_CORD:  if (cap_r || k_r == 6'(CORDIC_STEPS - 1)) state_nxt = S_POST;
      S_POST:  state_nxt = S_MULS;
      S_MULS:  state_nxt = S_MULC;
      S_MULC:  state_nxt = S_FUNC;
      S_FUNC:  state_nxt = S_DIV;
      S_DIV:   if (dcnt_r == 7'd0) state_nxt = S_UPD;
      S_UPD:   state_nxt = S_CHECK;
      S_DONE:  if (!ovalid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!ovalid_r || !out_stall)) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin : dp
    logic signed [63:0] r, xs, ys, ep, em, big, sm, cc, ss, fr, dr, mg, rat, na, dsh;
    logic [63:0] rm;
    case (state_r)
      S_IDLE: begin
        job_r <= job;
        a_r <= 64'(job.start);
        ov_r <= job.ov;
        steps_r <= '0;
        stop_r <= 1'b0;
        status_r <= (job.kind == KIND_PARABOLIC) ? ST_CONVERGED : ST_LIMIT;
      end
      S_RED: begin
        k_r <= '0;
        cap_r <= 1'b0;
        flip_r <= 1'b0;
        n_r <= '0;
        neg_r <= a_r[63];
        if (!hyp) begin
          // |a| in Q.30, reduced by compare-subtract of 8*pi, 4*pi and 2*pi in turn
          z_r <= (a_r[63] ? -a_r : a_r) <<< 4;
          rcnt_r <= 3'd2;
          x_r <= CIRC_GAIN;
          y_r <= '0;
          i_r <= 6'd0;
        end else begin
          // |h| in Q.30 plus half ln2, divided by ln2 by compare-subtract of 32*ln2 down to ln2
          z_r <= ((a_r[63] ? -a_r : a_r) <<< 4) + LN2_Q30 / 2;
          rcnt_r <= 3'd5;
          x_r <= HYP_GAIN_INV;
          y_r <= '0;
          i_r <= 6'd1;
          rep_r <= 6'd4;
        end
      end
      S_MOD: begin
        dsh = (hyp ? LN2_Q30 : TWO_PI_Q30) <<< rcnt_r;
        if (z_r >= dsh) begin
          z_r <= z_r - dsh;
          n_r <= n_r | (6'd1 << rcnt_r);
        end
        rcnt_r <= rcnt_r - 3'd1;
      end
      S_FOLD: begin
        if (!hyp) begin
          // remainder takes the sign of the angle
          r = neg_r ? -z_r : z_r;
          if (r > PI_Q30) r = r - TWO_PI_Q30;
          if (r < -PI_Q30) r = r + TWO_PI_Q30;
          if (r > HALF_PI_Q30) begin r = PI_Q30 - r; flip_r <= 1'b1; end
          else if (r < -HALF_PI_Q30) begin r = -PI_Q30 - r; flip_r <= 1'b1; end
          z_r <= r;
        end else begin
          z_r <= z_r - LN2_Q30 / 2;
          if (n_r >= 6'd24) cap_r <= 1'b1;
        end
      end
      S_CORD: begin
        xs = x_r >>> i_r;
        ys = y_r >>> i_r;
        if (!hyp) begin
          if (!z_r[63]) begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - circ_angle(i_r);
          end else begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + circ_angle(i_r);
          end
          i_r <= i_r + 6'd1;
        end else begin
          if (!z_r[63]) begin
            x_r <= x_r + ys; y_r <= y_r + xs; z_r <= z_r - hyp_angle(i_r);
          end else begin
            x_r <= x_r - ys; y_r <= y_r - xs; z_r <= z_r + hyp_angle(i_r);
          end
          if (i_r == rep_r) rep_r <= 6'(3 * rep_r + 1);
          else i_r <= i_r + 6'd1;
        end
        k_r <= k_r + 6'd1;
      end
      S_POST: begin
        if (!hyp) begin
          s_r <= y_r >>> 4;
          c_r <= flip_r ? -(x_r >>> 4) : (x_r >>> 4);
        end else if (cap_r) begin
          c_r <= MAG_CAP;
          s_r <= neg_r ? -MAG_CAP : MAG_CAP;
        end else begin
          ep = x_r + y_r; em = x_r - y_r;
          if (ep < 0) ep = 0;
          if (em < 0) em = 0;
          big = ep <<< n_r;
          sm = ep - ep + (em >>> n_r);
          cc = (big + sm) >>> 5;
          ss = (big - sm) >>> 5;
          if (cc > MAG_CAP) cc = MAG_CAP;
          if (ss > MAG_CAP) ss = MAG_CAP;
          c_r <= cc;
          s_r <= neg_r ? -ss : ss;
        end
      end
      S_MULS: s_r <= mul_ecc(s_r, job_r.ecc);
      S_MULC: c_r <= mul_ecc(c_r, job_r.ecc);
      S_FUNC: begin
        if (hyp) begin
          fr = s_r - a_r - 64'(job_r.m);
          dr = c_r - ONE_Q26;
        end else begin
          fr = a_r - s_r - 64'(job_r.m);
          dr = ONE_Q26 - c_r;
        end
        if (sat_f(fr) || sat_f(dr)) ov_r <= 1'b1;
        fr = sat_w(fr); dr = sat_w(dr);
        num_r <= fr; den_r <= dr;
        mg = dr[63] ? -dr : dr;
        if (mg <= 64'(dfloor)) begin
          status_r <= ST_FLAT;
          dcnt_r <= 7'd0;
          stop_r <= 1'b1;
        end else begin
          dcnt_r <= 7'd58;
        end
        qneg_r <= fr[63] != dr[63];
        un_r <= (fr[63] ? 64'(-fr) : 64'(fr)) << 26;
        ud_r <= dr[63] ? 64'(-dr) : 64'(dr);
        rem_r <= '0;
        q_r <= '0;
      end
      S_DIV: begin
        // restoring divide of |num|<<26 by |den|, one bit a cycle
        if (dcnt_r != 7'd0) begin
          rm = {rem_r[62:0], un_r[57]};
          un_r <= {un_r[62:0], 1'b0};
          if (rm >= ud_r) begin
            rem_r <= rm - ud_r; q_r <= {q_r[62:0], 1'b1};
          end else begin
            rem_r <= rm; q_r <= {q_r[62:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 7'd1;
        end
      end
      S_UPD: begin
        if (!stop_r) begin
          rat = (q_r >= (64'd1 << 48)) ? 64'sd1 <<< 50 : $signed(q_r);
          if (qneg_r) rat = -rat;
          if (sat_f(rat)) ov_r <= 1'b1;
          rat = sat_w(rat);
          na = a_r - rat;
          if (sat_f(na)) ov_r <= 1'b1;
          a_r <= sat_w(na);
          steps_r <= steps_r + 10'd1;
          mg = rat[63] ? -rat : rat;
          if (mg <= 64'(tol)) begin
            status_r <= ST_CONVERGED;
            stop_r <= 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!ovalid_r || !out_stall) begin
          out_r.anomaly <= a_r[31:0];
          out_r.orbit_kind <= job_r.kind;
          out_r.status <= ov_r ? ST_SATURATED : status_r;
          out_r.iterations_used <= steps_r;
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/kepler_equation_newton_solver_unit.sv
`timescale 1ns / 1ps
// Each Newton step runs range reduction, CORDIC rotations, the e-multiplies and a
// 58-bit restoring divide; parabolic items take no Newton step.
// Throughput: one item at a time in the Newton engine; a two-entry queue
// lets the next item be classified meanwhile.
// Reset (rst_n low, synchronous): queue and handshakes empty; limit 1000, tol 1, floor 1.
// ----------------------------------------------------------------------------
// kepler_equation_newton_solver_unit: Kepler equation Newton solver
// Front classifier, job queue, Newton engine and configuration registers.
// ----------------------------------------------------------------------------
module kepler_equation_newton_solver_unit
  import kens_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  kens_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output kens_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [9:0]  max_iter_r;
  logic [30:0] tol_r;
  logic [15:0] dfloor_r;
  logic        fv, fs, qv, qs;
  kens_job_t   fj, qj;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= 10'(ITER_DEFAULT);
      tol_r <= 31'd1;
      dfloor_r <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_ITER:
          max_iter_r <= (cfg_data[9:0] == 10'd0) ? 10'(ITER_DEFAULT) : cfg_data[9:0];
        REG_TOLERANCE:
          tol_r <= (cfg_data[30:0] == 31'd0) ? 31'd1 : cfg_data[30:0];
        REG_DERIV_FLOOR: dfloor_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  kens_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid(fv), .job_stall(fs), .job(fj)
  );

  kens_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_stall(fs), .wr_data(fj),
    .rd_valid(qv), .rd_stall(qs), .rd_data(qj)
  );

  kens_back u_back (
    .clk, .rst_n, .job_valid(qv), .job_stall(qs), .job(qj),
    .max_iter(max_iter_r), .tol(tol_r), .dfloor(dfloor_r),
    .out_valid, .out_stall, .out_data
  );

endmodule

### hw/rtl/kens_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kens_checker: port-level checks for the Kepler solver
// Handshake stability and result code sanity.
// ----------------------------------------------------------------------------
module kens_checker
  import kens_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input kens_out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("input transaction dropped while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.orbit_kind != 2'd3)
    else $error("bad orbit kind");

  a_parab: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.orbit_kind == KIND_PARABOLIC |->
      out_data.iterations_used == 10'd0)
    else $error("parabolic result shows steps");

  a_conv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_CONVERGED &&
      out_data.orbit_kind != KIND_PARABOLIC |-> out_data.iterations_used != 10'd0)
    else $error("converged without a step");

endmodule

bind kepler_equation_newton_solver_unit kens_checker u_kens_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
